@@ rtl/wpk_pkg.sv @@
// Shared types and constants for the word pattern key generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package wpk_pkg;

    // Letter slots carried by the input and result fields
    localparam int SLOTS     = 15;
    localparam int LOW_SLOTS = 8;
    // Bytes available in the rack key field
    localparam int KEY_BYTES = 7;

    typedef logic [7:0] letter_t;

    // One input transaction
    typedef struct packed {
        logic [63:0] word_low_bytes;
        logic [55:0] word_high_bytes;
        logic [3:0]  word_len;
        logic [14:0] wildcard_mask;
        logic [31:0] word_id;
    } wpk_in_t;

    // One result transaction
    typedef struct packed {
        logic        record_valid;
        logic [63:0] fixed_low_bytes;
        logic [55:0] fixed_high_bytes;
        logic [63:0] keep_low_bytes;
        logic [55:0] keep_high_bytes;
        logic [14:0] fixed_positions;
        logic [3:0]  pattern_length;
        logic [55:0] rack_key;
        logic [2:0]  rack_count;
        logic [31:0] word_id_out;
    } wpk_out_t;

    // Letter at slot idx of a word (slots 0..14)
    function automatic letter_t letter_at(input wpk_in_t item, input logic [3:0] idx);
        logic [SLOTS*8-1:0] row;
        row = {item.word_high_bytes, item.word_low_bytes};
        return row[{idx, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

@@ rtl/wpk_cell.sv @@
// One cell of the sorting chain: inserts the letter of its own slot into
// the running sorted rack when that slot is a wildcard. Uses wpk_pkg.
`default_nettype none

module wpk_cell
    import wpk_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int RACK_LIMIT = 7,
    parameter int CW         = 4
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire wpk_in_t                     in_item,
    input  wire letter_t [RACK_LIMIT-1:0]    in_rack,
    input  wire logic [CW-1:0]               in_cnt,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output wpk_in_t                          out_item,
    output letter_t [RACK_LIMIT-1:0]         out_rack,
    output logic [CW-1:0]                    out_cnt
);

    // Count saturates one past the limit: that alone marks an overflow
    localparam logic [CW-1:0] CNT_OVER = CW'(RACK_LIMIT + 1);
    localparam logic [3:0]    POS      = 4'(IDX);

    logic                       valid_reg;
    wpk_in_t                    item_reg;
    letter_t [RACK_LIMIT-1:0]   rack_reg;
    logic [CW-1:0]              cnt_reg;

    letter_t                    letter;
    logic                       is_wild;
    logic [RACK_LIMIT-1:0]      le;
    letter_t [RACK_LIMIT-1:0]   rack_ins;
    logic [CW-1:0]              cnt_ins;

    // Wildcard test for this slot, only below the word length
    always_comb begin
        letter  = letter_at(in_item, POS);
        is_wild = in_item.wildcard_mask[IDX] && (in_item.word_len > POS);
    end

    // Entries that stay put: occupied and not above the new letter
    always_comb begin
        for (int j = 0; j < RACK_LIMIT; j++) begin
            le[j] = (CW'(j) < in_cnt) && (in_rack[j] <= letter);
        end
    end

    // Sorted insert: the letter lands after the last staying entry,
    // everything above it moves up one place
    always_comb begin
        rack_ins[0] = le[0] ? in_rack[0] : letter;
        for (int j = 1; j < RACK_LIMIT; j++) begin
            if (le[j]) begin
                rack_ins[j] = in_rack[j];
            end else if (le[j-1]) begin
                rack_ins[j] = letter;
            end else begin
                rack_ins[j] = in_rack[j-1];
            end
        end
        cnt_ins = (in_cnt == CNT_OVER) ? in_cnt : in_cnt + CW'(1);
    end

    // Stage handshake: a bubble or a moving successor frees the stage
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
            rack_reg <= is_wild ? rack_ins : in_rack;
            cnt_reg  <= is_wild ? cnt_ins : in_cnt;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_rack  = rack_reg;
    assign out_cnt   = cnt_reg;

endmodule

`default_nettype wire

@@ rtl/wpk_out_stage.sv @@
// Output stage: checks the record, forms the fixed and keep bytes and the
// rack key, and holds the result register. Uses wpk_pkg.
`default_nettype none

module wpk_out_stage
    import wpk_pkg::*;
#(
    parameter int ROW_WIDTH  = 15,
    parameter int RACK_LIMIT = 7,
    parameter int CW         = 4
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire wpk_in_t                     in_item,
    input  wire letter_t [RACK_LIMIT-1:0]    in_rack,
    input  wire logic [CW-1:0]               in_cnt,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output wpk_out_t                         m_data
);

    localparam logic [4:0]    ROW_LIM   = 5'(ROW_WIDTH);
    localparam logic [CW-1:0] RACK_LIM  = CW'(RACK_LIMIT);
    localparam int            KEY_USED  = (RACK_LIMIT < KEY_BYTES) ? RACK_LIMIT : KEY_BYTES;

    logic                   m_valid_reg;
    wpk_out_t               m_data_reg;
    wpk_out_t               rec;

    logic                   len_ok;
    logic                   cnt_ok;
    logic [SLOTS-1:0]       active;
    logic [SLOTS-1:0]       fixed;
    logic [SLOTS*8-1:0]     fixed_row;
    logic [SLOTS*8-1:0]     keep_row;
    logic [KEY_BYTES*8-1:0] key;
    logic [CW+2:0]          cnt_ext;

    // Validity of length and wildcard count
    always_comb begin
        len_ok  = (in_item.word_len != 4'd0) && ({1'b0, in_item.word_len} <= ROW_LIM);
        cnt_ok  = (in_cnt != '0) && (in_cnt <= RACK_LIM);
        cnt_ext = {3'b000, in_cnt};
    end

    // Fixed positions and their byte slots
    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            active[k] = 4'(k) < in_item.word_len;
        end
        fixed = active & ~in_item.wildcard_mask;
        for (int k = 0; k < SLOTS; k++) begin
            fixed_row[8*k +: 8] = fixed[k] ? letter_at(in_item, 4'(k)) : 8'h00;
            keep_row[8*k +: 8]  = fixed[k] ? 8'hFF : 8'h00;
        end
    end

    // Rack key: sorted letters from byte 0, zero past the count
    always_comb begin
        key = '0;
        for (int j = 0; j < KEY_USED; j++) begin
            key[8*j +: 8] = (CW'(j) < in_cnt) ? in_rack[j] : 8'h00;
        end
    end

    // Record assembly; an invalid record keeps only the word id
    always_comb begin
        rec             = '0;
        rec.word_id_out = in_item.word_id;
        if (len_ok && cnt_ok) begin
            rec.record_valid     = 1'b1;
            rec.fixed_low_bytes  = fixed_row[LOW_SLOTS*8-1:0];
            rec.fixed_high_bytes = fixed_row[SLOTS*8-1:LOW_SLOTS*8];
            rec.keep_low_bytes   = keep_row[LOW_SLOTS*8-1:0];
            rec.keep_high_bytes  = keep_row[SLOTS*8-1:LOW_SLOTS*8];
            rec.fixed_positions  = fixed;
            rec.pattern_length   = in_item.word_len;
            rec.rack_key         = key;
            rec.rack_count       = cnt_ext[2:0];
        end
    end

    // Result register
    assign in_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_ready) begin
            m_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            m_data_reg <= rec;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

@@ rtl/word_pattern_key_generator_unit.sv @@
// Top level of the word pattern key generator: a chain of sorting cells,
// one per letter slot, followed by the output stage. Uses wpk_pkg.
//
//   channel   direction   ports                       payload
//   s_        in          s_valid s_ready s_data      wpk_in_t
//   m_        out         m_valid m_ready m_data      wpk_out_t
//
// One transaction per cycle sustained while m_ready stays high; each one passes
// one cell per letter slot up to ROW_WIDTH, then the result register.
// Each cell and the result register has its own valid bit, so bubbles close
// up while the result side stalls and s_ready stays high until all fill.
// Reset clears only the valid bits; payload registers are not reset.
`default_nettype none

module word_pattern_key_generator_unit
    import wpk_pkg::*;
#(
    parameter int ROW_WIDTH  = 15,
    parameter int RACK_LIMIT = 7
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire wpk_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output wpk_out_t      m_data
);

    // Slots beyond ROW_WIDTH only occur in invalid records
    localparam int NUM_CELLS = (ROW_WIDTH < SLOTS) ? ROW_WIDTH : SLOTS;
    localparam int CW        = $clog2(RACK_LIMIT + 2);

    logic [NUM_CELLS:0]         chain_valid;
    logic [NUM_CELLS:0]         chain_ready;
    wpk_in_t                    chain_item [NUM_CELLS+1];
    letter_t [RACK_LIMIT-1:0]   chain_rack [NUM_CELLS+1];
    logic [CW-1:0]              chain_cnt  [NUM_CELLS+1];

    // Head of the chain: empty rack
    assign chain_valid[0] = s_valid;
    assign s_ready        = chain_ready[0];
    assign chain_item[0]  = s_data;
    assign chain_rack[0]  = '0;
    assign chain_cnt[0]   = '0;

    // Sorting cells, one per slot
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        wpk_cell #(
            .IDX        (g),
            .RACK_LIMIT (RACK_LIMIT),
            .CW         (CW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_item   (chain_item[g]),
            .in_rack   (chain_rack[g]),
            .in_cnt    (chain_cnt[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_item  (chain_item[g+1]),
            .out_rack  (chain_rack[g+1]),
            .out_cnt   (chain_cnt[g+1])
        );
    end

    // Record formatting and result register
    wpk_out_stage #(
        .ROW_WIDTH  (ROW_WIDTH),
        .RACK_LIMIT (RACK_LIMIT),
        .CW         (CW)
    ) u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (chain_valid[NUM_CELLS]),
        .in_ready (chain_ready[NUM_CELLS]),
        .in_item  (chain_item[NUM_CELLS]),
        .in_rack  (chain_rack[NUM_CELLS]),
        .in_cnt   (chain_cnt[NUM_CELLS]),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

@@ rtl/wpk_checker.sv @@
// Port-level checks for the word pattern key generator, bound to the top.
// Uses wpk_pkg.
`default_nettype none

module wpk_checker
    import wpk_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire wpk_in_t  s_data,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire wpk_out_t m_data
);

    // A stalled input transaction stays put
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input changed while stalled");

    // A stalled result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Invalid records carry nothing but the word id
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.record_valid |->
            m_data.fixed_low_bytes == '0 && m_data.fixed_high_bytes == '0 &&
            m_data.keep_low_bytes == '0 && m_data.keep_high_bytes == '0 &&
            m_data.fixed_positions == '0 && m_data.pattern_length == '0 &&
            m_data.rack_key == '0 && m_data.rack_count == '0)
        else $error("invalid record has nonzero fields");

    // Valid record: fixed positions lie below the length, at least one wildcard
    a_valid_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.record_valid |->
            m_data.pattern_length != 4'd0 &&
            (m_data.fixed_positions >> m_data.pattern_length) == '0 &&
            $countones(m_data.fixed_positions) < 32'(m_data.pattern_length))
        else $error("valid record with bad length or fixed mask");

    // Keep bytes follow the fixed mask at both ends of the row
    a_keep_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            m_data.keep_low_bytes[7:0] == {8{m_data.fixed_positions[0]}} &&
            m_data.keep_high_bytes[55:48] == {8{m_data.fixed_positions[14]}})
        else $error("keep bytes disagree with fixed positions");

endmodule

bind word_pattern_key_generator_unit wpk_checker u_wpk_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
